// ----- rtl/core/rit_pkg.sv -----
// ----------------------------------------------------------------------------
// rit_pkg
// Shared constants, types and the digit glyph function for the radix
// integer to text converter.
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 8;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int IDX_W       = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 8'd36;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_ERR   = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 8'h37;   // 'A' - 10
    localparam logic [DIGIT_W-1:0] DEC_LIMIT  = 6'd10;

    // divider control and status
    typedef struct packed {
        logic load;    // new dividend and radix
        logic next;    // divide the held quotient again
    } t_div_ctl;

    typedef struct packed {
        logic               done;
        logic               q_zero;
        logic [DIGIT_W-1:0] digit;
    } t_div_stat;

    // digit store write port
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [DIGIT_W-1:0] digit;
    } t_wr;

    // emitter launch
    typedef struct packed {
        logic             start;
        logic             err;
        logic             neg;
        logic [CNT_W-1:0] count;
    } t_emit_ctl;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_LIMIT) begin
            return CHAR_ZERO + dx;
        end
        return CHAR_ALPHA + dx;
    endfunction

endpackage

// ----- rtl/core/rit_if.sv -----
// ----------------------------------------------------------------------------
// rit_if
// Valid/ready channels: input word (number, radix) and output word
// (one character with its flags).
// ----------------------------------------------------------------------------
interface rit_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rit_pkg::VALUE_WIDTH-1:0] number;
    logic [rit_pkg::RADIX_W-1:0]           radix;

    modport source (output valid, output number, output radix, input ready);
    modport sink   (input valid, input number, input radix, output ready);
endinterface

interface rit_out_if;
    logic                       valid;
    logic                       ready;
    logic [rit_pkg::CHAR_W-1:0] text_char;
    logic                       final_char;
    logic                       bad_radix;

    modport source (output valid, output text_char, output final_char,
                    output bad_radix, input ready);
    modport sink   (input valid, input text_char, input final_char,
                    input bad_radix, output ready);
endinterface

// ----- rtl/core/rit_div.sv -----
// ----------------------------------------------------------------------------
// rit_div
// Bit-serial restoring divider: one quotient bit per cycle. Keeps the
// quotient in its shift register so the next digit can follow directly.
// ----------------------------------------------------------------------------
module rit_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rit_pkg::t_div_ctl                i_ctl,
    input  logic [rit_pkg::VALUE_WIDTH-1:0]  i_dividend,
    input  logic [rit_pkg::DIGIT_W-1:0]      i_radix,
    output rit_pkg::t_div_stat               o_stat
);

    logic [rit_pkg::VALUE_WIDTH-1:0] r_q;
    logic [rit_pkg::DIGIT_W-1:0]     r_rem;
    logic [rit_pkg::DIGIT_W-1:0]     r_radix;
    logic [rit_pkg::IDX_W-1:0]       r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic                            r_nz;

    logic [rit_pkg::DIGIT_W:0]       rem_sh;
    logic [rit_pkg::DIGIT_W:0]       rem_sub;
    logic                            q_bit;
    logic [rit_pkg::DIGIT_W-1:0]     n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_q[rit_pkg::VALUE_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, r_radix};
        q_bit   = (rem_sh >= {1'b0, r_radix});
        n_rem   = q_bit ? rem_sub[rit_pkg::DIGIT_W-1:0] : rem_sh[rit_pkg::DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_nz   <= 1'b0;
            r_q    <= '0;
            r_rem  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.load || i_ctl.next) begin
                r_q    <= i_ctl.load ? i_dividend : r_q;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_nz   <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[rit_pkg::VALUE_WIDTH-2:0], q_bit};
                r_rem <= n_rem;
                r_nz  <= r_nz | q_bit;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rit_pkg::IDX_W'(rit_pkg::VALUE_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_radix <= i_radix;
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.q_zero = !r_nz;
    assign o_stat.digit  = r_rem;

endmodule

// ----- rtl/core/rit_emit.sv -----
// ----------------------------------------------------------------------------
// rit_emit
// Digit store and character emitter. Digits arrive least significant
// first; they are read back in reverse and driven out one word at a time
// through the output register.
// ----------------------------------------------------------------------------
module rit_emit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rit_pkg::t_wr           i_wr,
    input  rit_pkg::t_emit_ctl     i_ctl,
    output logic                   o_busy,
    rit_out_if.source              o_out
);

    logic [rit_pkg::DIGIT_W-1:0] r_mem [rit_pkg::VALUE_WIDTH];
    logic [rit_pkg::DIGIT_W-1:0] r_rd_data;

    logic [rit_pkg::CNT_W-1:0]   r_left;
    logic                        r_minus;
    logic                        r_err;

    logic                        r_out_valid;
    logic [rit_pkg::CHAR_W-1:0]  r_char;
    logic                        r_final;
    logic                        r_bad;

    logic                        slot_free;
    logic                        take_digit;
    logic                        rd_en;
    logic [rit_pkg::CNT_W-1:0]   rd_ptr;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign take_digit = slot_free && !r_err && !r_minus && (r_left != '0);

    // prefetch: launch reads the top digit, each consumed digit reads the next
    always_comb begin
        rd_en  = i_ctl.start || take_digit;
        rd_ptr = i_ctl.start ? (i_ctl.count - 1'b1) : (r_left - 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.digit;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_ptr[rit_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_minus     <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.start) begin
                r_err   <= i_ctl.err;
                r_minus <= i_ctl.neg && !i_ctl.err;
                r_left  <= i_ctl.err ? '0 : i_ctl.count;
            end else if (slot_free) begin
                if (r_err) begin
                    r_err       <= 1'b0;
                    r_out_valid <= 1'b1;
                end else if (r_minus) begin
                    r_minus     <= 1'b0;
                    r_out_valid <= 1'b1;
                end else if (r_left != '0) begin
                    r_left      <= r_left - 1'b1;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (!i_ctl.start && slot_free) begin
            if (r_err) begin
                r_char  <= rit_pkg::CHAR_ERR;
                r_final <= 1'b1;
                r_bad   <= 1'b1;
            end else if (r_minus) begin
                r_char  <= rit_pkg::CHAR_MINUS;
                r_final <= 1'b0;
                r_bad   <= 1'b0;
            end else if (r_left != '0) begin
                r_char  <= rit_pkg::glyph(r_rd_data);
                r_final <= (r_left == rit_pkg::CNT_W'(1));
                r_bad   <= 1'b0;
            end
        end
    end

    assign o_busy           = r_err || r_minus || (r_left != '0);
    assign o_out.valid      = r_out_valid;
    assign o_out.text_char  = r_char;
    assign o_out.final_char = r_final;
    assign o_out.bad_radix  = r_bad;

endmodule

// ----- rtl/core/radix_integer_to_text.sv -----
// ----------------------------------------------------------------------------
// radix_integer_to_text
// Converts a signed 32-bit number to ASCII text in base 2..36, one
// character per output word, most significant digit first.
// ----------------------------------------------------------------------------
// Each input word yields its text as a run of output words: '-' for a
// negative number, then digits '0'-'9'/'A'-'Z', with final_char set on
// the last one. A radix outside 2..36 yields one word with text_char 0,
// final_char 1 and bad_radix 1. Digits are produced by a bit-serial
// divider that takes one quotient bit per cycle, one digit after
// another; the longest conversion is base 2 with the most negative
// number. A new word is taken once the previous text has been handed
// to the output register; the last character may still be waiting
// there while the next conversion runs.
module radix_integer_to_text (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rit_in_if.sink    i_in,
    rit_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIV    = 4'b0010,
        S_LAUNCH = 4'b0100,
        S_DRAIN  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [rit_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_neg, n_neg;
    logic                        r_err, n_err;

    rit_pkg::t_div_ctl           div_ctl;
    rit_pkg::t_div_stat          div_stat;
    rit_pkg::t_wr                wr;
    rit_pkg::t_emit_ctl          emit_ctl;
    logic                        emit_busy;

    logic                        accept;
    logic                        radix_ok;
    logic [rit_pkg::VALUE_WIDTH-1:0] magnitude;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign radix_ok   = (i_in.radix >= rit_pkg::RADIX_MIN) &&
                        (i_in.radix <= rit_pkg::RADIX_MAX);
    assign magnitude  = i_in.number[rit_pkg::VALUE_WIDTH-1]
                      ? (rit_pkg::VALUE_WIDTH'(0) - rit_pkg::VALUE_WIDTH'(i_in.number))
                      : rit_pkg::VALUE_WIDTH'(i_in.number);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_neg        = r_neg;
        n_err        = r_err;
        div_ctl      = '0;
        wr.en        = 1'b0;
        wr.addr      = r_count[rit_pkg::IDX_W-1:0];
        wr.digit     = div_stat.digit;
        emit_ctl.start = 1'b0;
        emit_ctl.err   = r_err;
        emit_ctl.neg   = r_neg;
        emit_ctl.count = r_count;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count = '0;
                    n_neg   = i_in.number[rit_pkg::VALUE_WIDTH-1];
                    n_err   = !radix_ok;
                    if (radix_ok) begin
                        div_ctl.load = 1'b1;
                        n_state      = S_DIV;
                    end else begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    wr.en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (div_stat.q_zero ||
                        r_count == rit_pkg::CNT_W'(rit_pkg::VALUE_WIDTH - 1)) begin
                        n_state = S_LAUNCH;
                    end else begin
                        div_ctl.next = 1'b1;
                    end
                end
            end
            S_LAUNCH: begin
                emit_ctl.start = 1'b1;
                n_state        = S_DRAIN;
            end
            S_DRAIN: begin
                if (!emit_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_neg   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_neg   <= n_neg;
            r_err   <= n_err;
        end
    end

    rit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (magnitude),
        .i_radix    (i_in.radix[rit_pkg::DIGIT_W-1:0]),
        .o_stat     (div_stat)
    );

    rit_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_ctl   (emit_ctl),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix integer to text converter: a directed
// table of edge cases followed by random conversions. Every output word is
// checked against the expected text, with random idling on both channels and
// one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM    = 135;
    localparam int HOLD_CYCLES = 1500;    // longer than a base-2 conversion
    localparam int DRAIN_WAIT  = 50;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [rit_pkg::CHAR_W-1:0] text_char;
        logic                       final_char;
        logic                       bad_radix;
    } t_char_word;

    typedef enum {ROW_PREDICT, ROW_TEXT, ROW_BAD_RADIX} t_row_kind;

    typedef struct {
        logic [rit_pkg::VALUE_WIDTH-1:0] number;
        logic [rit_pkg::RADIX_W-1:0]     radix;
        t_row_kind                       kind;
        string                           text;
    } t_dir_row;

    t_dir_row dir_tab [25] = '{
        '{32'd0,          8'd10,  ROW_TEXT,      "0"},
        '{32'd0,          8'd2,   ROW_TEXT,      "0"},
        '{32'd1,          8'd2,   ROW_TEXT,      "1"},
        '{32'h7FFFFFFF,   8'd16,  ROW_TEXT,      "7FFFFFFF"},
        '{32'h80000000,   8'd16,  ROW_TEXT,      "-80000000"},
        '{32'h80000000,   8'd2,   ROW_TEXT,
          {"-1", "0000000000", "0000000000", "0000000000", "0"}},
        '{32'h7FFFFFFF,   8'd2,   ROW_PREDICT,   ""},
        '{32'hFFFFFFFF,   8'd10,  ROW_TEXT,      "-1"},
        '{32'h7FFFFFFF,   8'd10,  ROW_TEXT,      "2147483647"},
        '{32'h80000000,   8'd10,  ROW_TEXT,      "-2147483648"},
        '{32'h80000001,   8'd10,  ROW_TEXT,      "-2147483647"},
        '{32'd35,         8'd36,  ROW_TEXT,      "Z"},
        '{32'd36,         8'd36,  ROW_TEXT,      "10"},
        '{32'h80000000,   8'd36,  ROW_PREDICT,   ""},
        '{32'h7FFFFFFF,   8'd36,  ROW_PREDICT,   ""},
        '{32'hFFFFFF01,   8'd16,  ROW_TEXT,      "-FF"},
        '{32'd12345,      8'd10,  ROW_TEXT,      "12345"},
        '{32'd10,         8'd11,  ROW_TEXT,      "A"},
        '{32'hFFFFFF9C,   8'd3,   ROW_PREDICT,   ""},
        '{32'd5,          8'd0,   ROW_BAD_RADIX, ""},
        '{32'd5,          8'd1,   ROW_BAD_RADIX, ""},
        '{32'd5,          8'd37,  ROW_BAD_RADIX, ""},
        '{32'hFFFFFFFF,   8'd255, ROW_BAD_RADIX, ""},
        '{32'd0,          8'd128, ROW_BAD_RADIX, ""},
        '{32'h12345678,   8'd35,  ROW_PREDICT,   ""}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rit_in_if  in_ch ();
    rit_out_if out_ch ();

    radix_integer_to_text u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_char_word text_q [$];
    int         fail_cnt  = 0;
    int         cycle_cnt = 0;
    int         hold_left = 0;
    logic       hold_req  = 1'b0;
    logic       hold_done = 1'b0;
    logic       calm      = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [rit_pkg::CHAR_W-1:0] digit_to_ascii(
        input logic [rit_pkg::DIGIT_W-1:0] d);
        logic [rit_pkg::CHAR_W-1:0] dw;
        dw = {{(rit_pkg::CHAR_W-rit_pkg::DIGIT_W){1'b0}}, d};
        if (d < 6'd10) begin
            return rit_pkg::CHAR_ZERO + dw;
        end
        return 8'h41 + dw - 8'd10;
    endfunction

    function automatic void push_bad_radix();
        text_q.push_back('{rit_pkg::CHAR_ERR, 1'b1, 1'b1});
    endfunction

    // expected characters for one conversion, most significant digit first
    function automatic void predict_text(input logic [rit_pkg::VALUE_WIDTH-1:0] num,
                                         input logic [rit_pkg::RADIX_W-1:0] rad);
        logic [rit_pkg::VALUE_WIDTH-1:0] mag;
        logic [rit_pkg::VALUE_WIDTH-1:0] base;
        logic [rit_pkg::DIGIT_W-1:0]     digs [rit_pkg::VALUE_WIDTH];
        int                              n;
        if (rad < rit_pkg::RADIX_MIN || rad > rit_pkg::RADIX_MAX) begin
            push_bad_radix();
            return;
        end
        base = {{(rit_pkg::VALUE_WIDTH-rit_pkg::RADIX_W){1'b0}}, rad};
        mag  = num[rit_pkg::VALUE_WIDTH-1] ? (~num + 1'b1) : num;
        n    = 0;
        do begin
            digs[n] = rit_pkg::DIGIT_W'(mag % base);
            mag     = mag / base;
            n++;
        end while (mag != 0 && n < rit_pkg::VALUE_WIDTH);
        if (num[rit_pkg::VALUE_WIDTH-1]) begin
            text_q.push_back('{rit_pkg::CHAR_MINUS, 1'b0, 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            text_q.push_back('{digit_to_ascii(digs[i]), i == 0, 1'b0});
        end
    endfunction

    function automatic logic [rit_pkg::VALUE_WIDTH-1:0] pick_number();
        logic [rit_pkg::VALUE_WIDTH-1:0] v;
        case ($urandom_range(3))
            0: begin
                return $urandom;
            end
            1: begin
                return 32'($urandom_range(2000)) - 32'd1000;
            end
            2: begin
                if ($urandom_range(1) == 0) begin
                    return 32'h80000000 + 32'($urandom_range(3));
                end
                return 32'h7FFFFFFF - 32'($urandom_range(3));
            end
            default: begin
                v = $urandom >> $urandom_range(31);
                return ($urandom_range(1) == 0) ? -v : v;
            end
        endcase
    endfunction

    function automatic logic [rit_pkg::RADIX_W-1:0] pick_radix();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) begin
            return rit_pkg::RADIX_W'($urandom_range(1));
        end
        if (sel < 14) begin
            return rit_pkg::RADIX_W'($urandom_range(255, 37));
        end
        if (sel < 24) begin
            return rit_pkg::RADIX_MIN;
        end
        return rit_pkg::RADIX_W'($urandom_range(36, 2));
    endfunction

    // offer one word, return at the edge where it is taken
    task automatic send_word(input logic [rit_pkg::VALUE_WIDTH-1:0] num,
                             input logic [rit_pkg::RADIX_W-1:0] rad);
        if (!calm && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (!calm && $urandom_range(99) < 30) begin
                @(posedge i_clk);
            end
        end
        in_ch.valid  <= 1'b1;
        in_ch.number <= num;
        in_ch.radix  <= rad;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_char();
        t_char_word want;
        if (text_q.size() == 0) begin
            $error("unexpected output word: text_char %h final_char %b bad_radix %b",
                   out_ch.text_char, out_ch.final_char, out_ch.bad_radix);
            fail_cnt++;
            return;
        end
        want = text_q.pop_front();
        if (out_ch.text_char !== want.text_char) begin
            $error("text_char: expected %h, got %h", want.text_char, out_ch.text_char);
            fail_cnt++;
        end
        if (out_ch.final_char !== want.final_char) begin
            $error("final_char: expected %b, got %b", want.final_char, out_ch.final_char);
            fail_cnt++;
        end
        if (out_ch.bad_radix !== want.bad_radix) begin
            $error("bad_radix: expected %b, got %b", want.bad_radix, out_ch.bad_radix);
            fail_cnt++;
        end
    endtask

    // output side: checking, random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_char();
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else if (hold_req && !hold_done) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [rit_pkg::VALUE_WIDTH-1:0] num;
        logic [rit_pkg::RADIX_W-1:0]     rad;
        string                           s;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.number <= '0;
        in_ch.radix  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            send_word(dir_tab[r].number, dir_tab[r].radix);
            case (dir_tab[r].kind)
                ROW_TEXT: begin
                    s = dir_tab[r].text;
                    for (int i = 0; i < s.len(); i++) begin
                        text_q.push_back('{s[i], i == s.len() - 1, 1'b0});
                    end
                end
                ROW_BAD_RADIX: begin
                    push_bad_radix();
                end
                default: begin
                    predict_text(dir_tab[r].number, dir_tab[r].radix);
                end
            endcase
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            calm <= (k >= 80 && k < 120);
            if (k == 40) begin
                hold_req <= 1'b1;
            end
            num = pick_number();
            rad = pick_radix();
            send_word(num, rad);
            predict_text(num, rad);
        end
        in_ch.valid <= 1'b0;

        while (text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
